// ===== sv/spas_pkg.sv =====
// ----------------------------------------------------------------------------
// spas_pkg
// Shared types and constants for the sparse polynomial add/sub unit.
// ----------------------------------------------------------------------------
package spas_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned EXP_W  = 16;
  localparam int unsigned RES_W  = 33;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ADD    = 2'd2,
    OP_SUB    = 2'd3
  } op_e;

  typedef struct packed {
    logic                     is_merge;
    logic                     sel_b;
    logic                     sub;
    logic                     first;
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  expo;
  } cmd_t;

endpackage

// ===== sv/spas_front.sv =====
// ----------------------------------------------------------------------------
// spas_front
// Accepts input words, decodes the operation and queues the commands for the
// merge engine in a two-entry queue.
// ----------------------------------------------------------------------------
module spas_front
  import spas_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [COEF_W-1:0] coefficient_i,
  input  logic [EXP_W-1:0]         exponent_i,
  input  logic                     first_term_i,
  output logic                     head_valid_o,
  output cmd_t                     head_o,
  input  logic                     pop_i
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd;
  op_e        op;

  assign op = op_e'(operation_i);

  always_comb begin
    cmd.is_merge = 1'b0;
    cmd.sel_b    = 1'b0;
    cmd.sub      = 1'b0;
    cmd.first    = first_term_i;
    cmd.coef     = coefficient_i;
    cmd.expo     = exponent_i;
    case (op)
      OP_LOAD_A: cmd.sel_b = 1'b0;
      OP_LOAD_B: cmd.sel_b = 1'b1;
      OP_ADD:    cmd.is_merge = 1'b1;
      OP_SUB: begin
        cmd.is_merge = 1'b1;
        cmd.sub      = 1'b1;
      end
      default:   cmd.is_merge = 1'b0;
    endcase
  end

  assign stall_o      = (cnt_q == 2'd2);
  assign push         = valid_i && !stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = queue_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// ===== sv/spas_back.sv =====
// ----------------------------------------------------------------------------
// spas_back
// Holds the two term lists, performs loads and runs the sorted merge, one merge
// step per cycle unless output stalls, holding one term back to mark the last.
// ----------------------------------------------------------------------------
module spas_back
  import spas_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  cmd_t                    head_i,
  output logic                    pop_o,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [RES_W-1:0] result_coefficient_o,
  output logic [EXP_W-1:0]        result_exponent_o,
  output logic                    last_term_o,
  output logic                    empty_result_o,
  output logic                    overflow_o
);

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e state_q;

  logic signed [COEF_W-1:0] a_coef_q [MAX_TERMS];
  logic        [EXP_W-1:0]  a_exp_q  [MAX_TERMS];
  logic signed [COEF_W-1:0] b_coef_q [MAX_TERMS];
  logic        [EXP_W-1:0]  b_exp_q  [MAX_TERMS];

  logic [CW-1:0] a_cnt_q, b_cnt_q, ia_q, ib_q;
  logic          ovf_q, sub_q;

  logic                    pend_v_q;
  logic signed [RES_W-1:0] pend_coef_q;
  logic [EXP_W-1:0]        pend_exp_q;

  logic                    out_v_q, out_last_q, out_empty_q, out_ovf_q;
  logic signed [RES_W-1:0] out_coef_q;
  logic [EXP_W-1:0]        out_exp_q;

  logic                    a_live, b_live, take_a, take_b, done, keep, out_ready;
  logic                    out_load;
  logic signed [RES_W-1:0] ca, cb, st_coef;
  logic [EXP_W-1:0]        ea, eb, st_exp;
  logic [CW-1:0]           cur_cnt, eff_cnt;

  assign ca = RES_W'(a_coef_q[ia_q[IW-1:0]]);
  assign cb = RES_W'(b_coef_q[ib_q[IW-1:0]]);
  assign ea = a_exp_q[ia_q[IW-1:0]];
  assign eb = b_exp_q[ib_q[IW-1:0]];

  assign a_live = (ia_q < a_cnt_q);
  assign b_live = (ib_q < b_cnt_q);
  assign done   = !a_live && !b_live;
  assign take_a = a_live && (!b_live || (ea >= eb));
  assign take_b = b_live && (!a_live || (eb >= ea));

  always_comb begin
    st_exp  = take_a ? ea : eb;
    st_coef = ca;
    if (take_a && take_b) begin
      st_coef = sub_q ? (ca - cb) : (ca + cb);
    end else if (take_b) begin
      st_coef = sub_q ? -cb : cb;
    end
    keep = !(take_a && take_b && (st_coef == '0));
  end

  assign out_ready = !out_v_q || !stall_i;
  assign out_load  = (state_q == ST_RUN) && out_ready && (done || (keep && pend_v_q));
  assign pop_o     = (state_q == ST_IDLE) && head_valid_i;

  assign cur_cnt = head_i.sel_b ? b_cnt_q : a_cnt_q;
  assign eff_cnt = head_i.first ? '0 : cur_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
      ia_q     <= '0;
      ib_q     <= '0;
      ovf_q    <= 1'b0;
      sub_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (head_i.is_merge) begin
              ia_q    <= '0;
              ib_q    <= '0;
              sub_q   <= head_i.sub;
              state_q <= ST_RUN;
            end else if (eff_cnt >= MAX_CNT) begin
              ovf_q <= 1'b1;
              if (head_i.sel_b) begin
                b_cnt_q <= eff_cnt;
              end else begin
                a_cnt_q <= eff_cnt;
              end
            end else if (head_i.sel_b) begin
              b_cnt_q <= eff_cnt + CW'(1);
            end else begin
              a_cnt_q <= eff_cnt + CW'(1);
            end
          end
        end
        ST_RUN: begin
          if (done) begin
            if (out_ready) begin
              out_coef_q  <= pend_v_q ? pend_coef_q : '0;
              out_exp_q   <= pend_v_q ? pend_exp_q : '0;
              out_last_q  <= 1'b1;
              out_empty_q <= !pend_v_q;
              out_ovf_q   <= ovf_q;
              pend_v_q    <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end else if (!keep) begin
            ia_q <= ia_q + CW'(take_a);
            ib_q <= ib_q + CW'(take_b);
          end else if (!pend_v_q || out_ready) begin
            if (pend_v_q) begin
              out_coef_q  <= pend_coef_q;
              out_exp_q   <= pend_exp_q;
              out_last_q  <= 1'b0;
              out_empty_q <= 1'b0;
              out_ovf_q   <= ovf_q;
            end
            pend_v_q    <= 1'b1;
            pend_coef_q <= st_coef;
            pend_exp_q  <= st_exp;
            ia_q        <= ia_q + CW'(take_a);
            ib_q        <= ib_q + CW'(take_b);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // term storage
  always_ff @(posedge clk_i) begin
    if (pop_o && !head_i.is_merge && (eff_cnt < MAX_CNT)) begin
      if (head_i.sel_b) begin
        b_coef_q[eff_cnt[IW-1:0]] <= head_i.coef;
        b_exp_q[eff_cnt[IW-1:0]]  <= head_i.expo;
      end else begin
        a_coef_q[eff_cnt[IW-1:0]] <= head_i.coef;
        a_exp_q[eff_cnt[IW-1:0]]  <= head_i.expo;
      end
    end
  end

  assign valid_o              = out_v_q;
  assign result_coefficient_o = out_coef_q;
  assign result_exponent_o    = out_exp_q;
  assign last_term_o          = out_last_q;
  assign empty_result_o       = out_empty_q;
  assign overflow_o           = out_ovf_q;

endmodule

// ===== sv/sparse_polynomial_add_sub_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub_unit
// The merge engine takes load words back to back; a two-entry queue
// lets input words arrive every cycle while the engine is free.
// An add/sub run holds the engine for a dispatch step, the merge steps
// (a_count + b_count steps at most), a step to close the run and any
// output stalls; the first word goes through the dispatch and the
// held-back term, an empty result only through the closing step.
// Reset clears the queue, term counts, overflow flag and output valid flag.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_sub_unit
  import spas_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [COEF_W-1:0] coefficient_i,
  input  logic [EXP_W-1:0]         exponent_i,
  input  logic                     first_term_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [RES_W-1:0]  result_coefficient_o,
  output logic [EXP_W-1:0]         result_exponent_o,
  output logic                     last_term_o,
  output logic                     empty_result_o,
  output logic                     overflow_o
);

  logic head_valid, pop;
  cmd_t head;

  spas_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .operation_i   (operation_i),
    .coefficient_i (coefficient_i),
    .exponent_i    (exponent_i),
    .first_term_i  (first_term_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  spas_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_valid_i         (head_valid),
    .head_i               (head),
    .pop_o                (pop),
    .valid_o              (valid_o),
    .stall_i              (stall_i),
    .result_coefficient_o (result_coefficient_o),
    .result_exponent_o    (result_exponent_o),
    .last_term_o          (last_term_o),
    .empty_result_o       (empty_result_o),
    .overflow_o           (overflow_o)
  );

`ifndef ASSERT_OFF
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_result_o) |-> last_term_o)
    else $error("empty result word not marked last");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_result_o) |-> (result_coefficient_o == '0 && result_exponent_o == '0))
    else $error("empty result word carries a term");
`endif

endmodule
